### rtl/core/pmid_pkg.sv
package pmid_pkg;

    // Result and intermediate widths (fixed by the Q11.10 result format)
    localparam int DIST_W = 21;
    localparam int OUT_W  = 24;                 // distance padded to whole bytes
    localparam int MAG_W  = DIST_W + 1;         // clamped component magnitude
    localparam int SQ_W   = 2 * MAG_W;          // squared magnitude and squared sum
    localparam int RAD_W  = 2 * DIST_W;         // radicand bits fed to the root
    localparam int REM_W  = DIST_W + 1;         // root remainder
    localparam int CNT_W  = $clog2(DIST_W);
    localparam int REG_W  = 60;                 // lattice register width
    localparam int DATA_W = 64;                 // configuration data bus
    localparam int ADDR_W = 5;                  // four registers at 8-byte spacing

    localparam logic [DIST_W-1:0] DIST_MAX  = '1;
    localparam logic [MAG_W-1:0]  MAG_CLAMP = MAG_W'(1) << DIST_W;
    localparam logic [SQ_W-1:0]   SQ_SAT_LIMIT = SQ_W'(DIST_MAX) * SQ_W'(DIST_MAX);
    localparam logic [CNT_W-1:0]  ROOT_LAST = CNT_W'(DIST_W - 1);

    typedef enum logic [1:0] {
        REG_LAT_A,
        REG_LAT_B,
        REG_LAT_C,
        REG_DIMS
    } t_reg;

    // Lattice translation multiple: -1, 0, +1
    typedef enum logic [1:0] {
        OFS_NEG,
        OFS_ZERO,
        OFS_POS
    } t_ofs;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_ROOT,
        S_DONE
    } t_state;

    function automatic t_ofs ofs_next(t_ofs c);
        case (c)
            OFS_NEG:  ofs_next = OFS_ZERO;
            OFS_ZERO: ofs_next = OFS_POS;
            default:  ofs_next = OFS_POS;
        endcase
    endfunction

endpackage

### rtl/core/periodic_min_image_distance_core.sv
// Channel   | Direction | Transaction contents
// ----------+-----------+--------------------------------------------------------------
// s_axis    | in        | tdata: first_x, first_y, first_z, second_x, second_y, second_z
// m_axis    | out       | tdata: distance; tuser: saturated
// apb       | in/out    | 0x00 lattice a, 0x08 lattice b, 0x10 lattice c, 0x18 dims
//
// After input accept, the N image offsets (1, 3, 9 or 27 for 0..3 periodic dims) go
// one per cycle through a four-stage clamp/square/sum/min pipe; once the pipe has
// drained, the square root unit resolves one result bit per cycle. Input ready is
// high only in idle.
// Reset is synchronous, active low, and clears the configuration and control state registers.
// A stalled output holds its result; the next transaction may be accepted meanwhile, and
// its result waits in the final state until the output register is free.
module periodic_min_image_distance_core
    import pmid_pkg::*;
#(
    parameter int COORD_WIDTH = 20
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // first_x, first_y, first_z, second_x, second_y, second_z, then zero pad
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    // distance, then zero pad
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [OUT_W-1:0]                       m_axis_tdata,
    // saturated
    output logic                                   m_axis_tuser,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [ADDR_W-1:0]                      paddr,
    input  logic [DATA_W-1:0]                      pwdata,
    output logic [DATA_W-1:0]                      prdata,
    output logic                                   pready
);

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 3;                     // base plus three lattice terms
    localparam int AW = (DW > MAG_W) ? DW : MAG_W;  // magnitude compare width
    localparam int PW = (3 * CW > REG_W) ? 3 * CW : REG_W;

    // ---------------------------------------------------------------- configuration
    logic [REG_W-1:0] r_lat_a, r_lat_b, r_lat_c;
    logic [1:0]       r_dims;
    t_reg             w_reg_sel;

    assign w_reg_sel = t_reg'(paddr[ADDR_W-1:3]);
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_a <= '0;
            r_lat_b <= '0;
            r_lat_c <= '0;
            r_dims  <= '0;
        end else if (psel && penable && pwrite) begin
            case (w_reg_sel)
                REG_LAT_A: r_lat_a <= pwdata[REG_W-1:0];
                REG_LAT_B: r_lat_b <= pwdata[REG_W-1:0];
                REG_LAT_C: r_lat_c <= pwdata[REG_W-1:0];
                REG_DIMS:  r_dims  <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_sel)
            REG_LAT_A: prdata = DATA_W'(r_lat_a);
            REG_LAT_B: prdata = DATA_W'(r_lat_b);
            REG_LAT_C: prdata = DATA_W'(r_lat_c);
            REG_DIMS:  prdata = DATA_W'(r_dims);
            default:   prdata = '0;
        endcase
    end

    // Lattice components: bits above the 60-bit register read as zero
    logic [PW-1:0]          w_ext_a, w_ext_b, w_ext_c;
    logic signed [CW-1:0]   w_va [3];
    logic signed [CW-1:0]   w_vb [3];
    logic signed [CW-1:0]   w_vc [3];

    assign w_ext_a = PW'(r_lat_a);
    assign w_ext_b = PW'(r_lat_b);
    assign w_ext_c = PW'(r_lat_c);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_va[k] = signed'(w_ext_a[k*CW +: CW]);
            w_vb[k] = signed'(w_ext_b[k*CW +: CW]);
            w_vc[k] = signed'(w_ext_c[k*CW +: CW]);
        end
    end

    // ---------------------------------------------------------------- sequencer
    t_state r_state, n_state;
    t_ofs   r_ca, r_cb, r_cc, n_ca, n_cb, n_cc;
    t_ofs   w_first_a, w_first_b, w_first_c, w_last_a, w_last_b, w_last_c;
    logic   w_accept, w_issue, w_last_img, w_pipe_busy, w_out_free;
    logic   r_v1, r_v2, r_v3;
    logic   r_out_valid;
    logic [CNT_W-1:0] r_cnt;

    // Directions beyond periodic_dims stay at the zero offset
    assign w_first_a = (r_dims >= 2'd1) ? OFS_NEG : OFS_ZERO;
    assign w_first_b = (r_dims >= 2'd2) ? OFS_NEG : OFS_ZERO;
    assign w_first_c = (r_dims == 2'd3) ? OFS_NEG : OFS_ZERO;
    assign w_last_a  = (r_dims >= 2'd1) ? OFS_POS : OFS_ZERO;
    assign w_last_b  = (r_dims >= 2'd2) ? OFS_POS : OFS_ZERO;
    assign w_last_c  = (r_dims == 2'd3) ? OFS_POS : OFS_ZERO;

    assign w_last_img  = (r_ca == w_last_a) && (r_cb == w_last_b) && (r_cc == w_last_c);
    assign w_pipe_busy = r_v1 || r_v2 || r_v3;
    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_accept    = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state       = r_state;
        n_ca          = r_ca;
        n_cb          = r_cb;
        n_cc          = r_cc;
        s_axis_tready = 1'b0;
        w_issue       = 1'b0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_ca    = w_first_a;
                    n_cb    = w_first_b;
                    n_cc    = w_first_c;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                w_issue = 1'b1;
                // Advance c fastest, then b, then a
                if (r_cc != w_last_c) begin
                    n_cc = ofs_next(r_cc);
                end else begin
                    n_cc = w_first_c;
                    if (r_cb != w_last_b) begin
                        n_cb = ofs_next(r_cb);
                    end else begin
                        n_cb = w_first_b;
                        n_ca = ofs_next(r_ca);
                    end
                end
                if (w_last_img) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!w_pipe_busy) begin
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ca    <= OFS_ZERO;
            r_cb    <= OFS_ZERO;
            r_cc    <= OFS_ZERO;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ca    <= n_ca;
            r_cb    <= n_cb;
            r_cc    <= n_cc;
            r_v1    <= w_issue;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
        end
    end

    // ---------------------------------------------------------------- image pipe
    logic signed [CW:0] r_base [3];

    function automatic logic signed [DW-1:0] pick(t_ofs c, logic signed [CW-1:0] v);
        logic signed [DW-1:0] e;
        e = DW'(v);
        case (c)
            OFS_NEG: pick = -e;
            OFS_POS: pick = e;
            default: pick = '0;
        endcase
    endfunction

    logic signed [DW-1:0] w_d   [3];
    logic [DW-1:0]        w_abs [3];
    logic [MAG_W-1:0]     w_mag [3];

    // Stage 1: offset difference, magnitude, clamp to 2^21
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_d[k]   = DW'(r_base[k]) + pick(r_ca, w_va[k]) + pick(r_cb, w_vb[k])
                     + pick(r_cc, w_vc[k]);
            w_abs[k] = w_d[k][DW-1] ? unsigned'(-w_d[k]) : unsigned'(w_d[k]);
            w_mag[k] = (AW'(w_abs[k]) > AW'(MAG_CLAMP)) ? MAG_CLAMP
                                                          : MAG_W'(w_abs[k]);
        end
    end

    logic [MAG_W-1:0] r_mag [3];
    logic [SQ_W-1:0]  r_sq  [3];
    logic [SQ_W-1:0]  r_sum;
    logic [SQ_W-1:0]  r_best;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int k = 0; k < 3; k++) begin
                r_base[k] <= (CW+1)'(signed'(s_axis_tdata[(k+3)*CW +: CW]))
                           - (CW+1)'(signed'(s_axis_tdata[k*CW +: CW]));
            end
        end
        // Stages 2 and 3: square each lane, then add the lanes
        for (int k = 0; k < 3; k++) begin
            r_mag[k] <= w_mag[k];
            r_sq[k]  <= r_mag[k] * r_mag[k];
        end
        r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
        // Stage 4: keep the least squared distance
        if (w_accept) begin
            r_best <= '1;
        end else if (r_v3 && (r_sum < r_best)) begin
            r_best <= r_sum;
        end
    end

    // ---------------------------------------------------------------- square root
    // Digit-by-digit root, one result bit per cycle from the top radicand pair down
    logic [RAD_W-1:0]   r_rad;
    logic [REM_W-1:0]   r_rem;
    logic [DIST_W-1:0]  r_root;
    logic               r_sat;
    logic [REM_W+1:0]   w_rem_sh, w_trial;
    logic               w_fit;

    assign w_rem_sh = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign w_trial  = {1'b0, r_root, 2'b01};
    assign w_fit    = (w_rem_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (r_state == S_DRAIN) begin
            r_cnt <= ROOT_LAST;
        end else if (r_state == S_ROOT) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_DRAIN: begin
                r_rad  <= r_best[RAD_W-1:0];
                r_sat  <= (r_best > SQ_SAT_LIMIT);
                r_rem  <= '0;
                r_root <= '0;
            end
            S_ROOT: begin
                r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                r_rem  <= w_fit ? REM_W'(w_rem_sh - w_trial) : REM_W'(w_rem_sh);
                r_root <= {r_root[DIST_W-2:0], w_fit};
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- output register
    logic [DIST_W-1:0] r_dist;
    logic              r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_dist    <= r_sat ? DIST_MAX : r_root;
            r_out_sat <= r_sat;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_dist);
    assign m_axis_tuser  = r_out_sat;

endmodule

### rtl/core/pmid_checker.sv
module pmid_port_checker
    import pmid_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_tvalid,
    input logic             i_s_tready,
    input logic             i_m_tvalid,
    input logic             i_m_tready,
    input logic [OUT_W-1:0] i_m_tdata,
    input logic             i_m_tuser
);

    // A saturated result always reads full scale
    a_sat_full_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser |-> i_m_tdata[DIST_W-1:0] == DIST_MAX)
        else $error("saturated result does not read full scale");

    // Padding above the distance stays zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> i_m_tdata[OUT_W-1:DIST_W] == '0)
        else $error("distance padding not zero");

    // The block is busy, with input ready low, after taking a transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("input ready right after accept");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("stalled result changed");

endmodule

bind periodic_min_image_distance_core pmid_port_checker u_pmid_port_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);
